// File: hw/rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the pulse burst analyzer.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [WordWidth-1:0] NoneWidth = {WordWidth{1'b1}};
   localparam logic [WordWidth-1:0] NoiseThresholdReset = WordWidth'(100);
   localparam logic [WordWidth-1:0] BurstTimeoutReset = WordWidth'(100);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_NOISE_THRESHOLD = 1'b0,
      CSR_BURST_TIMEOUT   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                 pin_level;
      logic [WordWidth-1:0] now_us;
      logic [WordWidth-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                 burst_started;
      logic                 burst_ended;
      logic [WordWidth-1:0] burst_index;
      logic [WordWidth-1:0] pulses_in_burst;
      logic [WordWidth-1:0] min_width_us;
      logic [WordWidth-1:0] max_width_us;
      logic                 width_seen;
      logic                 indicator_level;
      logic                 burst_active;
   } rsp_type;

   typedef struct packed {
      logic we;
      logic [CsrIndexWidth-1:0] index;
      logic [WordWidth-1:0] data;
   } csr_type;

endpackage

// File: hw/rtl/pulse_burst_analyzer.sv
// ----------------------------------------------------------------------------
// pulse_burst_analyzer
// Burst and pulse-width statistics for an active-low receiver pin.
// ----------------------------------------------------------------------------
// Each request is one pin sample with microsecond and millisecond timestamps;
// each yields exactly one response with the burst state after that sample.
// A request is accepted every cycle when the response side keeps up. An
// accepted request waits in the input register while the update logic
// computes its response, which is loaded into the result register once that
// register is free or being emptied; the response is presented from there.
// The burst state is updated at the same edge that loads the result
// register, which allows the rate of one request per clock. Up to two
// requests are held while the response side stalls; then the request side
// stalls as well. Configuration writes take effect at the next cycle and
// should be made while no request is in flight.
// ----------------------------------------------------------------------------
module pulse_burst_analyzer
   import pba_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]     csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_pin_level,
   input  logic [WordWidth-1:0]     req_now_us,
   input  logic [WordWidth-1:0]     req_now_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_burst_started,
   output logic                     rsp_burst_ended,
   output logic [WordWidth-1:0]     rsp_burst_index,
   output logic [WordWidth-1:0]     rsp_pulses_in_burst,
   output logic [WordWidth-1:0]     rsp_min_width_us,
   output logic [WordWidth-1:0]     rsp_max_width_us,
   output logic                     rsp_width_seen,
   output logic                     rsp_indicator_level,
   output logic                     rsp_burst_active
);

   req_type req_item, item;
   csr_type csr;
   rsp_type result, rsp_result;
   logic    item_valid, can_load, fire;

   assign req_item.pin_level = req_pin_level;
   assign req_item.now_us    = req_now_us;
   assign req_item.now_ms    = req_now_ms;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   assign fire = item_valid && can_load;

   pba_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   pba_update u_update (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   pba_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (item_valid),
      .can_load   (can_load),
      .in_result  (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_burst_started   = rsp_result.burst_started;
   assign rsp_burst_ended     = rsp_result.burst_ended;
   assign rsp_burst_index     = rsp_result.burst_index;
   assign rsp_pulses_in_burst = rsp_result.pulses_in_burst;
   assign rsp_min_width_us    = rsp_result.min_width_us;
   assign rsp_max_width_us    = rsp_result.max_width_us;
   assign rsp_width_seen      = rsp_result.width_seen;
   assign rsp_indicator_level = rsp_result.indicator_level;
   assign rsp_burst_active    = rsp_result.burst_active;

endmodule

// File: hw/rtl/pba_in_stage.sv
// ----------------------------------------------------------------------------
// pba_in_stage
// Input register: holds one request until the update stage takes it.
// ----------------------------------------------------------------------------
module pba_in_stage
   import pba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   input  logic    take,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: hw/rtl/pba_update.sv
// ----------------------------------------------------------------------------
// pba_update
// Burst state and configuration registers with the per-sample update logic.
// ----------------------------------------------------------------------------
module pba_update
   import pba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic [WordWidth-1:0] threshold_ff, threshold_in;
   logic [WordWidth-1:0] timeout_ff, timeout_in;
   logic                 prev_level_ff, prev_level_in;
   logic                 active_ff, active_in;
   logic [WordWidth-1:0] burst_count_ff, burst_count_in;
   logic [WordWidth-1:0] last_edge_ff, last_edge_in;
   logic [WordWidth-1:0] fall_time_ff, fall_time_in;
   logic [WordWidth-1:0] pulses_ff, pulses_in;
   logic [WordWidth-1:0] min_width_ff, min_width_in;
   logic [WordWidth-1:0] max_width_ff, max_width_in;
   logic                 led_ff, led_in;

   logic                 falling, rising, start, timed_out;
   logic [WordWidth-1:0] width, idle_ms;

   always_comb begin
      threshold_in = threshold_ff;
      timeout_in   = timeout_ff;
      if (csr.we) begin
         unique case (csr_index_type'(csr.index))
            CSR_NOISE_THRESHOLD: threshold_in = csr.data;
            CSR_BURST_TIMEOUT:   timeout_in   = csr.data;
            default: ;
         endcase
      end
   end

   assign falling = prev_level_ff && !item.pin_level;
   assign rising  = !prev_level_ff && item.pin_level;
   assign start   = falling && !active_ff;
   assign width   = item.now_us - fall_time_ff;

   always_comb begin
      active_in      = active_ff;
      burst_count_in = burst_count_ff;
      pulses_in      = pulses_ff;
      min_width_in   = min_width_ff;
      max_width_in   = max_width_ff;
      led_in         = led_ff;
      fall_time_in   = fall_time_ff;
      last_edge_in   = last_edge_ff;
      if (falling) begin
         active_in      = 1'b1;
         fall_time_in   = item.now_us;
         last_edge_in   = item.now_ms;
         pulses_in      = pulses_ff + WordWidth'(1);
         if (start) begin
            burst_count_in = burst_count_ff + WordWidth'(1);
            pulses_in      = WordWidth'(1);
            min_width_in   = NoneWidth;
            max_width_in   = '0;
            led_in         = !led_ff;
         end
      end
      if (rising) begin
         last_edge_in = item.now_ms;
         if (width > threshold_ff) begin
            if (width < min_width_ff) begin
               min_width_in = width;
            end
            if (width > max_width_ff) begin
               max_width_in = width;
            end
         end
      end
      idle_ms   = item.now_ms - last_edge_in;
      timed_out = active_in && (idle_ms > timeout_ff);
      if (timed_out) begin
         active_in = 1'b0;
      end
      prev_level_in = item.pin_level;
   end

   always_comb begin
      result.burst_started   = start;
      result.burst_ended     = timed_out;
      result.burst_index     = burst_count_in;
      result.pulses_in_burst = pulses_in;
      result.min_width_us    = min_width_in;
      result.max_width_us    = max_width_in;
      result.width_seen      = (min_width_in != NoneWidth);
      result.indicator_level = led_in;
      result.burst_active    = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= NoiseThresholdReset;
         timeout_ff     <= BurstTimeoutReset;
         prev_level_ff  <= 1'b1;
         active_ff      <= 1'b0;
         burst_count_ff <= '0;
         last_edge_ff   <= '0;
         fall_time_ff   <= '0;
         pulses_ff      <= '0;
         min_width_ff   <= NoneWidth;
         max_width_ff   <= '0;
         led_ff         <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         timeout_ff   <= timeout_in;
         if (fire) begin
            prev_level_ff  <= prev_level_in;
            active_ff      <= active_in;
            burst_count_ff <= burst_count_in;
            last_edge_ff   <= last_edge_in;
            fall_time_ff   <= fall_time_in;
            pulses_ff      <= pulses_in;
            min_width_ff   <= min_width_in;
            max_width_ff   <= max_width_in;
            led_ff         <= led_in;
         end
      end
   end

endmodule

// File: hw/rtl/pba_out_stage.sv
// ----------------------------------------------------------------------------
// pba_out_stage
// Result register: holds one result until the response side takes it.
// ----------------------------------------------------------------------------
module pba_out_stage
   import pba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    can_load,
   input  rsp_type in_result,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_result
);

   logic    valid_ff, valid_in;
   rsp_type result_ff, result_in;
   logic    load;

   assign can_load = !valid_ff || rsp_ready;
   assign load     = in_valid && can_load;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = in_result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// File: tb/pulse_burst_analyzer_test.sv
// ----------------------------------------------------------------------------
// pulse_burst_analyzer_test
// Self-checking test of the pulse burst analyzer.
// ----------------------------------------------------------------------------
// Sends timestamped pin samples through the request channel and compares every
// response with a burst status computed in the test from the same samples.
// A short directed sequence covers timestamp wrap, the noise threshold, widths
// of all ones, rising edges outside a burst and the exact timeout boundary.
// Register extremes follow, then a response hold-off that fills the block, and
// random pulse trains mixed with noise under four handshake mixes.
// ----------------------------------------------------------------------------
module pulse_burst_analyzer_test;
   import pba_pkg::*;

   localparam int unsigned ClockPeriod = 20;
   localparam int unsigned DrainCycles = 4;
   localparam int unsigned RunLimitCycles = 200000;
   localparam int unsigned ItemsPerPhase = 360;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_NOISE_THRESHOLD;
   logic [WordWidth-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_pin_level = 1'b1;
   logic [WordWidth-1:0] req_now_us = '0;
   logic [WordWidth-1:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_burst_started;
   logic rsp_burst_ended;
   logic [WordWidth-1:0] rsp_burst_index;
   logic [WordWidth-1:0] rsp_pulses_in_burst;
   logic [WordWidth-1:0] rsp_min_width_us;
   logic [WordWidth-1:0] rsp_max_width_us;
   logic rsp_width_seen;
   logic rsp_indicator_level;
   logic rsp_burst_active;

   pulse_burst_analyzer dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pin_level(req_pin_level),
      .req_now_us(req_now_us),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_burst_started(rsp_burst_started),
      .rsp_burst_ended(rsp_burst_ended),
      .rsp_burst_index(rsp_burst_index),
      .rsp_pulses_in_burst(rsp_pulses_in_burst),
      .rsp_min_width_us(rsp_min_width_us),
      .rsp_max_width_us(rsp_max_width_us),
      .rsp_width_seen(rsp_width_seen),
      .rsp_indicator_level(rsp_indicator_level),
      .rsp_burst_active(rsp_burst_active)
   );

   // burst tracker state and register copies
   logic seen_level;
   logic in_burst;
   logic [WordWidth-1:0] burst_count;
   logic [WordWidth-1:0] edge_ms;
   logic [WordWidth-1:0] fall_us;
   logic [WordWidth-1:0] pulse_tally;
   logic [WordWidth-1:0] width_min;
   logic [WordWidth-1:0] width_max;
   logic led_on;
   logic [WordWidth-1:0] thr_us;
   logic [WordWidth-1:0] timeout_ms;

   rsp_type pending_status[$];
   logic [WordWidth-1:0] cur_us = '0;
   logic [WordWidth-1:0] cur_ms = '0;
   int samples_sent = 0;
   int status_checked = 0;
   int starts_seen = 0;
   int timeouts_seen = 0;
   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_left = 0;

   always begin
      #(ClockPeriod / 2) clock = 1'b1;
      #(ClockPeriod / 2) clock = 1'b0;
   end

   task automatic reset_tracker();
      seen_level = 1'b1;
      in_burst = 1'b0;
      burst_count = '0;
      edge_ms = '0;
      fall_us = '0;
      pulse_tally = '0;
      width_min = NoneWidth;
      width_max = '0;
      led_on = 1'b0;
      thr_us = NoiseThresholdReset;
      timeout_ms = BurstTimeoutReset;
   endtask

   function automatic rsp_type next_burst_status(req_type s);
      rsp_type st;
      logic [WordWidth-1:0] width;
      logic [WordWidth-1:0] elapsed;
      st = '0;
      if (seen_level && !s.pin_level) begin
         if (!in_burst) begin
            in_burst = 1'b1;
            burst_count = burst_count + 1;
            pulse_tally = '0;
            width_min = NoneWidth;
            width_max = '0;
            led_on = ~led_on;
            st.burst_started = 1'b1;
         end
         fall_us = s.now_us;
         pulse_tally = pulse_tally + 1;
         edge_ms = s.now_ms;
      end
      if (!seen_level && s.pin_level) begin
         width = s.now_us - fall_us;
         if (width > thr_us) begin
            if (width < width_min) width_min = width;
            if (width > width_max) width_max = width;
         end
         edge_ms = s.now_ms;
      end
      elapsed = s.now_ms - edge_ms;
      if (in_burst && elapsed > timeout_ms) begin
         in_burst = 1'b0;
         st.burst_ended = 1'b1;
      end
      seen_level = s.pin_level;
      st.burst_index = burst_count;
      st.pulses_in_burst = pulse_tally;
      st.min_width_us = width_min;
      st.max_width_us = width_max;
      st.width_seen = (width_min != NoneWidth);
      st.indicator_level = led_on;
      st.burst_active = in_burst;
      return st;
   endfunction

   task automatic send_sample(logic pin, logic [WordWidth-1:0] us, logic [WordWidth-1:0] ms);
      req_type s;
      s = '{pin_level: pin, now_us: us, now_ms: ms};
      cur_us = us;
      cur_ms = ms;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pin_level <= s.pin_level;
      req_now_us <= s.now_us;
      req_now_ms <= s.now_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_status.push_back(next_burst_status(s));
      samples_sent++;
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_config(logic [WordWidth-1:0] thr, logic [WordWidth-1:0] tmo);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_NOISE_THRESHOLD;
      csr_data <= thr;
      @(negedge clock);
      csr_index <= CSR_BURST_TIMEOUT;
      csr_data <= tmo;
      @(negedge clock);
      csr_we <= 1'b0;
      thr_us = thr;
      timeout_ms = tmo;
   endtask

   function automatic logic [WordWidth-1:0] pick_width();
      case ($urandom_range(5))
         0: return thr_us;
         1: return thr_us + 1;
         2: return thr_us - 1;
         3: return $urandom_range(0, 400);
         4: return $urandom_range(0, 5000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WordWidth-1:0] pick_gap();
      case ($urandom_range(5))
         0: return timeout_ms;
         1: return timeout_ms + 1;
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   task automatic send_pulse();
      logic [WordWidth-1:0] fall;
      fall = cur_us + $urandom_range(0, 20);
      send_sample(1'b0, fall, cur_ms + pick_gap());
      repeat ($urandom_range(0, 2)) send_sample(1'b0, fall + $urandom_range(0, 30),
                                                cur_ms + pick_gap());
      send_sample(1'b1, fall + pick_width(), cur_ms + pick_gap());
      repeat ($urandom_range(0, 2)) send_sample(1'b1, cur_us + $urandom_range(0, 30),
                                                cur_ms + pick_gap());
   endtask

   task automatic send_traffic(int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) begin
         if ($urandom_range(9) == 0) begin
            send_sample(1'($urandom_range(0, 1)), $urandom, $urandom);
         end else begin
            send_pulse();
         end
      end
   endtask

   task automatic test_directed_edges();
      send_sample(1'b1, 32'h0000_0000, 32'h0000_0000);
      send_sample(1'b0, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'h0000_0100, 32'h0000_0000);
      send_sample(1'b0, 32'h0000_0200, 32'h0000_0001);
      send_sample(1'b1, 32'h0000_0200 + 100, 32'h0000_0002);
      send_sample(1'b0, 32'h0000_0400, 32'h0000_0003);
      send_sample(1'b1, 32'h0000_0400 + 101, 32'h0000_0004);
      send_sample(1'b0, 32'h0000_0001, 32'h0000_0005);
      send_sample(1'b1, 32'h0000_0000, 32'h0000_0006);
      send_sample(1'b1, 32'h0000_0000, 32'h0000_0006 + 100);
      send_sample(1'b1, 32'h0000_0000, 32'h0000_0006 + 101);
      send_sample(1'b0, 32'hFFFF_FFFF, 32'h0000_00C8);
      send_sample(1'b0, 32'h0000_0005, 32'h0000_00FA);
      send_sample(1'b0, 32'h0000_0005, 32'h0000_00C8 + 101);
      send_sample(1'b1, 32'h0000_1000, 32'h0000_0200);
      send_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(1'b0, 32'h0000_0000, 32'h0000_0000);
      send_sample(1'b1, 32'h0000_0000, 32'h0000_0000);
      send_sample(1'b0, 32'h0000_0001, 32'h0000_000A);
      send_sample(1'b1, 32'h0000_0000, 32'h0000_000B);
      wait_for_responses();
   endtask

   task automatic test_register_extremes();
      write_config('0, '0);
      send_sample(1'b0, 32'd10, 32'd1000);
      send_sample(1'b1, 32'd10, 32'd1000);
      send_sample(1'b0, 32'd10, 32'd1000);
      send_sample(1'b1, 32'd11, 32'd1000);
      send_sample(1'b1, 32'd11, 32'd1001);
      wait_for_responses();
      write_config('1, '1);
      send_sample(1'b0, 32'h0000_0000, 32'h0000_0000);
      send_sample(1'b1, 32'hFFFF_FFFF, 32'h0000_0005);
      send_sample(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      wait_for_responses();
   endtask

   task automatic test_backpressure();
      write_config(NoiseThresholdReset, BurstTimeoutReset);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req = 300;
      send_traffic(60);
      wait_for_responses();
      send_traffic(20);
      wait_for_responses();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               write_config(NoiseThresholdReset, BurstTimeoutReset);
            end
            1: begin
               send_idle_pct = 83;
               stall_pct = 0;
               write_config($urandom_range(0, 300), $urandom_range(0, 20));
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 83;
               write_config('0, '0);
            end
            default: begin
               send_idle_pct = 37;
               stall_pct = 37;
               write_config($urandom_range(0, 1000), $urandom_range(0, 50));
            end
         endcase
         cur_us = 32'hFFFF_F000 + $urandom_range(0, 255);
         cur_ms = 32'hFFFF_FFC0 + $urandom_range(0, 15);
         send_traffic(ItemsPerPhase);
         wait_for_responses();
      end
   endtask

   // response side: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic check_field(string name, logic [WordWidth-1:0] want,
                              logic [WordWidth-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("response %0d, %s: expected %h, got %h", status_checked, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : check_responses
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{burst_started: rsp_burst_started, burst_ended: rsp_burst_ended,
                 burst_index: rsp_burst_index, pulses_in_burst: rsp_pulses_in_burst,
                 min_width_us: rsp_min_width_us, max_width_us: rsp_max_width_us,
                 width_seen: rsp_width_seen, indicator_level: rsp_indicator_level,
                 burst_active: rsp_burst_active};
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with no request outstanding");
         end else begin
            want = pending_status.pop_front();
            check_field("burst_started", WordWidth'(want.burst_started),
                        WordWidth'(got.burst_started));
            check_field("burst_ended", WordWidth'(want.burst_ended),
                        WordWidth'(got.burst_ended));
            check_field("burst_index", want.burst_index, got.burst_index);
            check_field("pulses_in_burst", want.pulses_in_burst, got.pulses_in_burst);
            check_field("min_width_us", want.min_width_us, got.min_width_us);
            check_field("max_width_us", want.max_width_us, got.max_width_us);
            check_field("width_seen", WordWidth'(want.width_seen),
                        WordWidth'(got.width_seen));
            check_field("indicator_level", WordWidth'(want.indicator_level),
                        WordWidth'(got.indicator_level));
            check_field("burst_active", WordWidth'(want.burst_active),
                        WordWidth'(got.burst_active));
            starts_seen += int'(got.burst_started);
            timeouts_seen += int'(got.burst_ended);
         end
         status_checked++;
      end
   end

   initial begin
      reset_tracker();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      if (pending_status.size() != 0) begin
         $display("%0d responses never arrived", pending_status.size());
         mismatches += pending_status.size();
      end
      $display("Sent %0d samples, checked %0d responses: %0d burst starts, %0d timeouts.",
               samples_sent, status_checked, starts_seen, timeouts_seen);
      $display("Four handshake mixes, a long response hold-off, registers from zero to ones.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(RunLimitCycles * ClockPeriod);
      $display("run limit reached with %0d responses outstanding", pending_status.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_in_stage.sv
hw/rtl/pba_update.sv
hw/rtl/pba_out_stage.sv
hw/rtl/pulse_burst_analyzer.sv
tb/pulse_burst_analyzer_test.sv
